### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BVCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define BVCS_NEVER(lbl, cond, msg) \
  `BVCS_ASSERT(lbl, !(cond), msg)

`endif

### src/bvcs_pkg.sv
package bvcs_pkg;

  // Vector geometry; input fields are fixed at 32 bits
  localparam int VECTOR_BITS = 32;
  localparam int IN_W        = 32;
  localparam int EFF_BITS    = (VECTOR_BITS < IN_W) ? VECTOR_BITS : IN_W;
  localparam logic [IN_W-1:0] DIM_MASK =
    IN_W'(64'hFFFF_FFFF_FFFF_FFFF >> (64 - EFF_BITS));

  // Result field widths
  localparam int CNT_W  = 6;
  localparam int SIM_W  = 16;
  localparam int PROD_W = 2 * CNT_W;

  // Divider: one quotient bit per step, a few steps per pipeline stage
  localparam int DIV_STEPS    = SIM_W;
  localparam int STEP_PER_STG = 2;
  localparam int DIV_STG      = DIV_STEPS / STEP_PER_STG;

  // Queues
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 16;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic [IN_W-1:0] vector_a;
    logic [IN_W-1:0] vector_b;
  } in_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [CNT_W-1:0] shared_count;
    logic [CNT_W-1:0] weight_a;
    logic [CNT_W-1:0] weight_b;
  } out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic             zero;
    logic [CNT_W-1:0] weight_a;
    logic [CNT_W-1:0] weight_b;
    logic [CNT_W-1:0] shared;
  } cnt_t;

  // Divider stage contents
  typedef struct packed {
    logic              zero;
    logic [CNT_W-1:0]  weight_a;
    logic [CNT_W-1:0]  weight_b;
    logic [CNT_W-1:0]  shared;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] rem;
    logic [SIM_W-1:0]  quo;
  } div_t;

  // Ones count of the masked vector, SWAR style
  function automatic logic [CNT_W-1:0] popcount(logic [IN_W-1:0] x);
    logic [IN_W-1:0] v;
    logic [7:0]      s;
    v = x & DIM_MASK;
    v = v - ((v >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0F0F_0F0F;
    s = v[7:0] + v[15:8] + v[23:16] + v[31:24];
    return s[CNT_W-1:0];
  endfunction

  // One restoring division step: quotient bit, then shift remainder
  function automatic div_t div_step(div_t s);
    div_t              o;
    logic              qb;
    logic [PROD_W-1:0] r;
    qb    = (s.rem >= s.den);
    r     = qb ? (s.rem - s.den) : s.rem;
    o     = s;
    o.rem = {r[PROD_W-2:0], 1'b0};
    o.quo = {s.quo[SIM_W-2:0], qb};
    return o;
  endfunction

endpackage

### src/bvcs_front.sv
module bvcs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  bvcs_pkg::in_t   in_data,
  input  logic            mid_deq,
  output logic            mid_valid,
  output bvcs_pkg::cnt_t  mid_item
);

  bvcs_pkg::cnt_t                q_r [bvcs_pkg::MID_DEPTH];
  logic [bvcs_pkg::MID_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bvcs_pkg::MID_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bvcs_pkg::MID_AW:0]     cnt_r, cnt_nxt;
  bvcs_pkg::cnt_t                item;
  logic                          push_ok;
  logic                          deq_ok;

  // Counts and zero-weight classification of the incoming beat
  always_comb begin
    item.weight_a = bvcs_pkg::popcount(in_data.vector_a);
    item.weight_b = bvcs_pkg::popcount(in_data.vector_b);
    item.shared   = bvcs_pkg::popcount(in_data.vector_a & in_data.vector_b);
    item.zero     = (item.weight_a == '0) || (item.weight_b == '0);
  end

  assign in_full   = (cnt_r == (bvcs_pkg::MID_AW+1)'(bvcs_pkg::MID_DEPTH));
  assign mid_valid = (cnt_r != '0);
  assign mid_item  = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign deq_ok    = mid_deq && mid_valid;

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + bvcs_pkg::MID_AW'(push_ok);
    rd_ptr_nxt = rd_ptr_r + bvcs_pkg::MID_AW'(deq_ok);
    cnt_nxt    = cnt_r + (bvcs_pkg::MID_AW+1)'(push_ok)
                       - (bvcs_pkg::MID_AW+1)'(deq_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  `include "assert_macros.svh"

  `BVCS_NEVER(a_mid_overfill,
              cnt_r > (bvcs_pkg::MID_AW+1)'(bvcs_pkg::MID_DEPTH),
              "mid queue overfilled")
  `BVCS_NEVER(a_deq_empty, mid_deq && !mid_valid, "dequeue from empty mid queue")
  `BVCS_ASSERT(a_ptr_gap,
               (wr_ptr_r - rd_ptr_r) == cnt_r[bvcs_pkg::MID_AW-1:0],
               "mid queue pointers disagree with count")

endmodule

### src/bvcs_div.sv
module bvcs_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  bvcs_pkg::cnt_t  in_item,
  output logic            out_vld,
  output bvcs_pkg::div_t  out_s
);

  bvcs_pkg::div_t                  s0_r;
  logic                            s0_vld_r;
  bvcs_pkg::div_t                  s0_nxt;
  bvcs_pkg::div_t                  st_r   [bvcs_pkg::DIV_STG];
  bvcs_pkg::div_t                  st_nxt [bvcs_pkg::DIV_STG];
  logic [bvcs_pkg::DIV_STG-1:0]    vld_r;
  logic [bvcs_pkg::CNT_W:0]        wsum;
  logic [bvcs_pkg::CNT_W-1:0]      half;

  // Entry stage: numerator and denominator products
  always_comb begin
    wsum             = {1'b0, in_item.weight_a} + {1'b0, in_item.weight_b};
    half             = wsum[bvcs_pkg::CNT_W:1];
    s0_nxt.zero      = in_item.zero;
    s0_nxt.weight_a  = in_item.weight_a;
    s0_nxt.weight_b  = in_item.weight_b;
    s0_nxt.shared    = in_item.shared;
    s0_nxt.den       = bvcs_pkg::PROD_W'(in_item.weight_a)
                     * bvcs_pkg::PROD_W'(in_item.weight_b);
    s0_nxt.rem       = bvcs_pkg::PROD_W'(half) * bvcs_pkg::PROD_W'(in_item.shared);
    s0_nxt.quo       = '0;
  end

  // Divider stages, a fixed number of quotient bits each
  always_comb begin
    bvcs_pkg::div_t t;
    for (int g = 0; g < bvcs_pkg::DIV_STG; g++) begin
      t = (g == 0) ? s0_r : st_r[(g == 0) ? 0 : g - 1];
      for (int k = 0; k < bvcs_pkg::STEP_PER_STG; k++) begin
        t = bvcs_pkg::div_step(t);
      end
      st_nxt[g] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      s0_vld_r <= in_vld;
      vld_r    <= {vld_r[bvcs_pkg::DIV_STG-2:0], s0_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    for (int g = 0; g < bvcs_pkg::DIV_STG; g++) begin
      st_r[g] <= st_nxt[g];
    end
  end

  assign out_vld = vld_r[bvcs_pkg::DIV_STG-1];
  assign out_s   = st_r[bvcs_pkg::DIV_STG-1];

endmodule

### src/bvcs_back.sv
module bvcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mid_valid,
  input  bvcs_pkg::cnt_t  mid_item,
  output logic            mid_deq,
  output logic            out_empty,
  input  logic            out_pop,
  output bvcs_pkg::out_t  out_data
);

  bvcs_pkg::out_t                oq_r [bvcs_pkg::OUT_DEPTH];
  logic [bvcs_pkg::OUT_AW-1:0]   owr_ptr_r, owr_ptr_nxt;
  logic [bvcs_pkg::OUT_AW-1:0]   ord_ptr_r, ord_ptr_nxt;
  logic [bvcs_pkg::OUT_AW:0]     ocnt_r, ocnt_nxt;
  logic [bvcs_pkg::OUT_AW:0]     occ_r, occ_nxt;
  logic                          issue;
  logic                          pop_ok;
  logic                          res_vld;
  bvcs_pkg::div_t                res_s;
  bvcs_pkg::out_t                res;

  // Issue only with a queue slot reserved for the result: pipeline never stalls
  assign issue   = mid_valid && (occ_r < (bvcs_pkg::OUT_AW+1)'(bvcs_pkg::OUT_DEPTH));
  assign mid_deq = issue;
  assign pop_ok  = out_pop && !out_empty;

  bvcs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (issue),
    .in_item (mid_item),
    .out_vld (res_vld),
    .out_s   (res_s)
  );

  // Result formatting; zero weight forces a zero score
  always_comb begin
    res.similarity   = res_s.zero ? '0 : res_s.quo;
    res.shared_count = res_s.shared;
    res.weight_a     = res_s.weight_a;
    res.weight_b     = res_s.weight_b;
  end

  assign out_empty = (ocnt_r == '0);
  assign out_data  = oq_r[ord_ptr_r];

  // Result queue and slot reservation count
  always_comb begin
    owr_ptr_nxt = owr_ptr_r + bvcs_pkg::OUT_AW'(res_vld);
    ord_ptr_nxt = ord_ptr_r + bvcs_pkg::OUT_AW'(pop_ok);
    ocnt_nxt    = ocnt_r + (bvcs_pkg::OUT_AW+1)'(res_vld)
                         - (bvcs_pkg::OUT_AW+1)'(pop_ok);
    occ_nxt     = occ_r + (bvcs_pkg::OUT_AW+1)'(issue)
                        - (bvcs_pkg::OUT_AW+1)'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
      occ_r     <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
      occ_r     <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      oq_r[owr_ptr_r] <= res;
    end
  end

  `include "assert_macros.svh"

  `BVCS_NEVER(a_occ_bound, occ_r > (bvcs_pkg::OUT_AW+1)'(bvcs_pkg::OUT_DEPTH), "reservation count overflow")
  `BVCS_NEVER(a_ocnt_le_occ, ocnt_r > occ_r, "result queue holds more than reserved")
  `BVCS_NEVER(a_zero_score, !out_empty && ((out_data.weight_a == '0) || (out_data.weight_b == '0)) && (out_data.similarity != '0), "nonzero score with zero weight")

endmodule

### src/bit_vector_cosine_similarity_top.sv
// Channel   Handshake            Payload
// input     in_push / in_full    in_data   (vector_a, vector_b)
// result    out_pop / out_empty  out_data  (similarity, shared_count, weight_a, weight_b)
//
// One pair accepted per cycle while in_full is low; a result shows on out_data once it has
// been written to the result queue, and can be popped at the next edge.
// Path: mid queue, product stage, 8 divider stages (2 quotient bits each), queue write.
// Synchronous active-low reset empties both queues; there is no clearing pass.
// A stalled result side fills the 16-entry result queue, then the 4-entry mid queue,
// then raises in_full.
module bit_vector_cosine_similarity_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  bvcs_pkg::in_t   in_data,
  output logic            out_empty,
  input  logic            out_pop,
  output bvcs_pkg::out_t  out_data
);

  logic            mid_valid;
  logic            mid_deq;
  bvcs_pkg::cnt_t  mid_item;

  bvcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .mid_deq   (mid_deq),
    .mid_valid (mid_valid),
    .mid_item  (mid_item)
  );

  bvcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_item  (mid_item),
    .mid_deq   (mid_deq),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
